// ----- rtl/gprd_pkg.sv -----
// shared types, constants and the microcode rom of the grid probe repaint decider
// no dependencies; used by gprd_seq, gprd_dp and grid_probe_repaint_decider_unit
`default_nettype none

package gprd_pkg;

  // grid and coordinate limits
  localparam int MAX_COLS   = 8;
  localparam int MAX_ROWS   = 8;
  localparam int COORD_BITS = 12;

  localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELL_BITS = COL_BITS + ROW_BITS;
  localparam int NUM_CELLS = 2 ** CELL_BITS;

  // register and field widths
  localparam int SIZE_BITS     = 12;
  localparam int GRID_BITS     = 4;
  localparam int THR_BITS      = 7;
  localparam int CNT_BITS      = 7;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 3;

  // divider for the probe margins: screen size over twice the probe count
  localparam int DIVR_BITS    = GRID_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

  // register reset values
  localparam logic [SIZE_BITS-1:0] RST_SCREEN_WIDTH  = SIZE_BITS'(600);
  localparam logic [SIZE_BITS-1:0] RST_SCREEN_HEIGHT = SIZE_BITS'(800);
  localparam logic [GRID_BITS-1:0] RST_PROBE_COLS    = GRID_BITS'(4);
  localparam logic [GRID_BITS-1:0] RST_PROBE_ROWS    = GRID_BITS'(4);
  localparam logic [THR_BITS-1:0]  RST_HIT_THRESHOLD = THR_BITS'(4);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_COLS    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_ROWS    = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_HIT_THRESHOLD = CFG_IDX_BITS'(4);

  // item modes
  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;
  } item_t;

  typedef struct packed {
    logic                full_repaint;
    logic [CNT_BITS-1:0] marked_count;
  } result_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_LOAD_H,
    OP_DIV_STEP,
    OP_SAVE_H_LOAD_V,
    OP_SAVE_V_ROW_INIT,
    OP_COL_INIT,
    OP_MARK_STEP,
    OP_ROW_STEP,
    OP_CNT_INIT,
    OP_CNT_STEP,
    OP_QUERY_OUT,
    OP_CLEAR
  } dp_op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_IS_QUERY,
    C_IS_CLEAR,
    C_NOT_MARK,
    C_DIV_MORE,
    C_ROW_OUT,
    C_COL_MORE,
    C_ROW_MORE,
    C_CNT_MORE
  } cond_e;

  localparam int PC_BITS = 4;

  typedef struct packed {
    dp_op_e             op;
    cond_e              cond;
    logic [PC_BITS-1:0] target;
    logic               done;
  } cw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic is_query;
    logic is_clear;
    logic not_mark;
    logic div_more;
    logic row_out;
    logic col_more;
    logic row_more;
    logic cnt_more;
  } status_t;

  // program addresses
  localparam logic [PC_BITS-1:0] S_DISPATCH = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] S_DISP_CLR = PC_BITS'(1);
  localparam logic [PC_BITS-1:0] S_DISP_BAD = PC_BITS'(2);
  localparam logic [PC_BITS-1:0] S_DIVH     = PC_BITS'(3);
  localparam logic [PC_BITS-1:0] S_DIVH_LP  = PC_BITS'(4);
  localparam logic [PC_BITS-1:0] S_DIVV     = PC_BITS'(5);
  localparam logic [PC_BITS-1:0] S_DIVV_LP  = PC_BITS'(6);
  localparam logic [PC_BITS-1:0] S_ROW_INIT = PC_BITS'(7);
  localparam logic [PC_BITS-1:0] S_COL_INIT = PC_BITS'(8);
  localparam logic [PC_BITS-1:0] S_MARK_LP  = PC_BITS'(9);
  localparam logic [PC_BITS-1:0] S_ROW_STEP = PC_BITS'(10);
  localparam logic [PC_BITS-1:0] S_END      = PC_BITS'(11);
  localparam logic [PC_BITS-1:0] S_CNT_INIT = PC_BITS'(12);
  localparam logic [PC_BITS-1:0] S_CNT_LP   = PC_BITS'(13);
  localparam logic [PC_BITS-1:0] S_QUERY    = PC_BITS'(14);
  localparam logic [PC_BITS-1:0] S_CLEAR    = PC_BITS'(15);

  function automatic cw_t ucode_rom(input logic [PC_BITS-1:0] pc);
    cw_t cw;
    cw = '{op: OP_NOP, cond: C_NEVER, target: S_END, done: 1'b1};
    unique case (pc)
      S_DISPATCH: cw = '{op: OP_NOP,             cond: C_IS_QUERY, target: S_CNT_INIT,
                         done: 1'b0};
      S_DISP_CLR: cw = '{op: OP_NOP,             cond: C_IS_CLEAR, target: S_CLEAR,
                         done: 1'b0};
      S_DISP_BAD: cw = '{op: OP_NOP,             cond: C_NOT_MARK, target: S_END,
                         done: 1'b0};
      S_DIVH:     cw = '{op: OP_DIV_LOAD_H,      cond: C_NEVER,    target: S_END,
                         done: 1'b0};
      S_DIVH_LP:  cw = '{op: OP_DIV_STEP,        cond: C_DIV_MORE, target: S_DIVH_LP,
                         done: 1'b0};
      S_DIVV:     cw = '{op: OP_SAVE_H_LOAD_V,   cond: C_NEVER,    target: S_END,
                         done: 1'b0};
      S_DIVV_LP:  cw = '{op: OP_DIV_STEP,        cond: C_DIV_MORE, target: S_DIVV_LP,
                         done: 1'b0};
      S_ROW_INIT: cw = '{op: OP_SAVE_V_ROW_INIT, cond: C_NEVER,    target: S_END,
                         done: 1'b0};
      S_COL_INIT: cw = '{op: OP_COL_INIT,        cond: C_ROW_OUT,  target: S_ROW_STEP,
                         done: 1'b0};
      S_MARK_LP:  cw = '{op: OP_MARK_STEP,       cond: C_COL_MORE, target: S_MARK_LP,
                         done: 1'b0};
      S_ROW_STEP: cw = '{op: OP_ROW_STEP,        cond: C_ROW_MORE, target: S_COL_INIT,
                         done: 1'b0};
      S_END:      cw = '{op: OP_NOP,             cond: C_NEVER,    target: S_END,
                         done: 1'b1};
      S_CNT_INIT: cw = '{op: OP_CNT_INIT,        cond: C_NEVER,    target: S_END,
                         done: 1'b0};
      S_CNT_LP:   cw = '{op: OP_CNT_STEP,        cond: C_CNT_MORE, target: S_CNT_LP,
                         done: 1'b0};
      S_QUERY:    cw = '{op: OP_QUERY_OUT,       cond: C_NEVER,    target: S_END,
                         done: 1'b1};
      S_CLEAR:    cw = '{op: OP_CLEAR,           cond: C_NEVER,    target: S_END,
                         done: 1'b1};
      default:    cw = '{op: OP_NOP,             cond: C_NEVER,    target: S_END,
                         done: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gprd_seq.sv -----
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on gprd_pkg
`default_nettype none

module gprd_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire gprd_pkg::status_t   status_i,
  output logic                     busy_o,
  output gprd_pkg::cw_t            cw_o
);

  logic                         busy_q;
  logic [gprd_pkg::PC_BITS-1:0] pc_q;
  gprd_pkg::cw_t                cw_rom;
  logic                         take;

  assign cw_rom = gprd_pkg::ucode_rom(pc_q);

  always_comb begin
    case (cw_rom.cond)
      gprd_pkg::C_IS_QUERY: take = status_i.is_query;
      gprd_pkg::C_IS_CLEAR: take = status_i.is_clear;
      gprd_pkg::C_NOT_MARK: take = status_i.not_mark;
      gprd_pkg::C_DIV_MORE: take = status_i.div_more;
      gprd_pkg::C_ROW_OUT:  take = status_i.row_out;
      gprd_pkg::C_COL_MORE: take = status_i.col_more;
      gprd_pkg::C_ROW_MORE: take = status_i.row_more;
      gprd_pkg::C_CNT_MORE: take = status_i.cnt_more;
      default:              take = 1'b0;
    endcase
  end

  // idle issues a no-op word so the datapath only moves while a program runs
  always_comb begin
    if (busy_q) begin
      cw_o = cw_rom;
    end else begin
      cw_o = '{op: gprd_pkg::OP_NOP, cond: gprd_pkg::C_NEVER,
               target: gprd_pkg::S_END, done: 1'b0};
    end
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= gprd_pkg::S_DISPATCH;
    end else if (!busy_q) begin
      if (start_i) begin
        busy_q <= 1'b1;
        pc_q   <= gprd_pkg::S_DISPATCH;
      end
    end else if (cw_rom.done) begin
      busy_q <= 1'b0;
    end else if (take) begin
      pc_q <= cw_rom.target;
    end else begin
      pc_q <= pc_q + gprd_pkg::PC_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gprd_dp.sv -----
// datapath: config registers, margin divider, probe scan, mark bits, counter, flag
// depends on gprd_pkg
`default_nettype none

module gprd_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 accept_i,
  input  wire gprd_pkg::item_t                      item_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [gprd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [gprd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  wire gprd_pkg::cw_t                        cw_i,
  output gprd_pkg::status_t                         status_o,
  output logic                                      result_valid_o,
  output gprd_pkg::result_t                         result_o
);

  // configuration
  logic [gprd_pkg::SIZE_BITS-1:0] width_q, height_q;
  logic [gprd_pkg::GRID_BITS-1:0] cols_q, rows_q;
  logic [gprd_pkg::THR_BITS-1:0]  thr_q;

  gprd_pkg::item_t item_q;

  // divider
  logic [gprd_pkg::COORD_BITS-1:0]   dvd_q, quo_q;
  logic [gprd_pkg::DIVR_BITS-1:0]    rem_q, divr_q, rem_d;
  logic [gprd_pkg::DIV_CNT_BITS-1:0] dcnt_q;
  logic [gprd_pkg::DIVR_BITS:0]      rem_sh;
  logic                              div_ge;

  // scan
  logic [gprd_pkg::COORD_BITS-1:0] hm_q, vm_q, x_q, y_q;
  logic [gprd_pkg::COL_BITS-1:0]   col_q;
  logic [gprd_pkg::ROW_BITS-1:0]   row_q;
  logic [gprd_pkg::CELL_BITS-1:0]  k_q;
  logic [gprd_pkg::CNT_BITS-1:0]   n_q;
  logic [gprd_pkg::NUM_CELLS-1:0]  marks_q;
  logic                            flag_q, flag_d;
  logic                            valid_q;
  gprd_pkg::result_t               result_q;
  logic                            in_col;

  // config write decode
  logic                           cfg_clear;
  logic [gprd_pkg::GRID_BITS-1:0] cfg_grid;
  logic [gprd_pkg::GRID_BITS-1:0] cfg_cols_sat, cfg_rows_sat;

  assign cfg_grid     = cfg_wdata_i[gprd_pkg::GRID_BITS-1:0];
  assign cfg_cols_sat = (32'(cfg_grid) > 32'(gprd_pkg::MAX_COLS))
                        ? gprd_pkg::GRID_BITS'(gprd_pkg::MAX_COLS) : cfg_grid;
  assign cfg_rows_sat = (32'(cfg_grid) > 32'(gprd_pkg::MAX_ROWS))
                        ? gprd_pkg::GRID_BITS'(gprd_pkg::MAX_ROWS) : cfg_grid;

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gprd_pkg::REG_SCREEN_WIDTH,
        gprd_pkg::REG_SCREEN_HEIGHT:
          cfg_clear = (cfg_wdata_i[gprd_pkg::SIZE_BITS-1:0] != '0);
        gprd_pkg::REG_PROBE_COLS,
        gprd_pkg::REG_PROBE_ROWS:
          cfg_clear = (cfg_grid != '0);
        gprd_pkg::REG_HIT_THRESHOLD:
          cfg_clear = (cfg_wdata_i[gprd_pkg::THR_BITS-1:0] != '0);
        default:
          cfg_clear = 1'b0;
      endcase
    end
  end

  // one restoring divide step
  assign rem_sh = {rem_q, dvd_q[gprd_pkg::COORD_BITS-1]};
  assign div_ge = (rem_sh >= {1'b0, divr_q});
  assign rem_d  = div_ge ? gprd_pkg::DIVR_BITS'(rem_sh - {1'b0, divr_q})
                         : gprd_pkg::DIVR_BITS'(rem_sh);

  assign in_col = (x_q >= item_q.rect_left) && (x_q < item_q.rect_right);
  assign flag_d = flag_q || (n_q >= thr_q);

  always_comb begin
    status_o.is_query = (item_q.mode == gprd_pkg::MODE_QUERY);
    status_o.is_clear = (item_q.mode == gprd_pkg::MODE_CLEAR);
    status_o.not_mark = (item_q.mode != gprd_pkg::MODE_MARK);
    status_o.div_more = (dcnt_q != '0);
    status_o.row_out  = (y_q < item_q.rect_top) || (y_q >= item_q.rect_bottom);
    status_o.col_more = ((gprd_pkg::GRID_BITS'(col_q) + gprd_pkg::GRID_BITS'(1)) != cols_q);
    status_o.row_more = ((gprd_pkg::GRID_BITS'(row_q) + gprd_pkg::GRID_BITS'(1)) != rows_q);
    status_o.cnt_more = (k_q != '1);
  end

  // control state: config, marks, flag, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gprd_pkg::RST_SCREEN_WIDTH;
      height_q <= gprd_pkg::RST_SCREEN_HEIGHT;
      cols_q   <= gprd_pkg::RST_PROBE_COLS;
      rows_q   <= gprd_pkg::RST_PROBE_ROWS;
      thr_q    <= gprd_pkg::RST_HIT_THRESHOLD;
      marks_q  <= '0;
      flag_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= (cw_i.op == gprd_pkg::OP_QUERY_OUT);
      if (cfg_clear) begin
        case (cfg_idx_i)
          gprd_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i[gprd_pkg::SIZE_BITS-1:0];
          gprd_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[gprd_pkg::SIZE_BITS-1:0];
          gprd_pkg::REG_PROBE_COLS:    cols_q   <= cfg_cols_sat;
          gprd_pkg::REG_PROBE_ROWS:    rows_q   <= cfg_rows_sat;
          gprd_pkg::REG_HIT_THRESHOLD: thr_q    <= cfg_wdata_i[gprd_pkg::THR_BITS-1:0];
          default:                     thr_q    <= thr_q;
        endcase
      end
      if (cfg_clear || (cw_i.op == gprd_pkg::OP_CLEAR)) begin
        marks_q <= '0;
        flag_q  <= 1'b0;
      end else if (cw_i.op == gprd_pkg::OP_MARK_STEP) begin
        if (in_col) begin
          marks_q[{row_q, col_q}] <= 1'b1;
        end
      end else if (cw_i.op == gprd_pkg::OP_CNT_STEP) begin
        // count pass rotates every mark past bit 0; a full pass restores the order
        marks_q <= {marks_q[0], marks_q[gprd_pkg::NUM_CELLS-1:1]};
      end else if (cw_i.op == gprd_pkg::OP_QUERY_OUT) begin
        flag_q <= flag_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    case (cw_i.op)
      gprd_pkg::OP_DIV_LOAD_H: begin
        dvd_q  <= gprd_pkg::COORD_BITS'(width_q);
        rem_q  <= '0;
        divr_q <= {cols_q, 1'b0};
        dcnt_q <= gprd_pkg::DIV_CNT_BITS'(gprd_pkg::COORD_BITS - 1);
      end
      gprd_pkg::OP_DIV_STEP: begin
        dvd_q  <= {dvd_q[gprd_pkg::COORD_BITS-2:0], 1'b0};
        rem_q  <= rem_d;
        quo_q  <= {quo_q[gprd_pkg::COORD_BITS-2:0], div_ge};
        dcnt_q <= dcnt_q - gprd_pkg::DIV_CNT_BITS'(1);
      end
      gprd_pkg::OP_SAVE_H_LOAD_V: begin
        hm_q   <= quo_q;
        dvd_q  <= gprd_pkg::COORD_BITS'(height_q);
        rem_q  <= '0;
        divr_q <= {rows_q, 1'b0};
        dcnt_q <= gprd_pkg::DIV_CNT_BITS'(gprd_pkg::COORD_BITS - 1);
      end
      gprd_pkg::OP_SAVE_V_ROW_INIT: begin
        vm_q  <= quo_q;
        y_q   <= quo_q;
        row_q <= '0;
      end
      gprd_pkg::OP_COL_INIT: begin
        x_q   <= hm_q;
        col_q <= '0;
      end
      gprd_pkg::OP_MARK_STEP: begin
        x_q   <= x_q + {hm_q[gprd_pkg::COORD_BITS-2:0], 1'b0};
        col_q <= col_q + gprd_pkg::COL_BITS'(1);
      end
      gprd_pkg::OP_ROW_STEP: begin
        y_q   <= y_q + {vm_q[gprd_pkg::COORD_BITS-2:0], 1'b0};
        row_q <= row_q + gprd_pkg::ROW_BITS'(1);
      end
      gprd_pkg::OP_CNT_INIT: begin
        k_q <= '0;
        n_q <= '0;
      end
      gprd_pkg::OP_CNT_STEP: begin
        n_q <= n_q + gprd_pkg::CNT_BITS'(marks_q[0]);
        k_q <= k_q + gprd_pkg::CELL_BITS'(1);
      end
      gprd_pkg::OP_QUERY_OUT: begin
        result_q.full_repaint <= flag_d;
        result_q.marked_count <= n_q;
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// ----- rtl/grid_probe_repaint_decider_unit.sv -----
// top level of the grid probe repaint decider
// depends on gprd_pkg, gprd_seq and gprd_dp
`default_nettype none

// grid probe repaint decider. an item is taken when start is high and busy is
// low; busy stays high until the item is done and the next one can be given.
// the result of a query comes out on result_o with result_valid_o high for
// exactly one cycle and must be taken then: there is no way to hold it off.
// each mode runs as a microcode program, one control word per cycle:
// - mark: two margin divides, then a scan of every probe of each row
//   whose y lies in the rectangle; a row that misses is skipped
// - query: a count pass over all 64 mark bits, result strobe in the
//   same cycle that busy falls
// - clear: clears all marks and the repaint flag; unused mode: no effect
// config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and
// belong to idle time only; a nonzero write to a known register also clears
// all marks and the repaint flag, a zero write or unknown index is ignored

module grid_probe_repaint_decider_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire gprd_pkg::item_t                     item_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [gprd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [gprd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output logic                                     result_valid_o,
  output gprd_pkg::result_t                        result_o
);

  // item transfer
  logic              accept;
  gprd_pkg::cw_t     cw;
  gprd_pkg::status_t status;

  assign accept = start && !busy;

  // program control: dispatch on mode, divide loops, row/column scan, count loop
  gprd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .busy_o   (busy),
    .cw_o     (cw)
  );

  // datapath driven by the control word
  gprd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cw_i           (cw),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
